// ===== sv/tbb_pkg.sv =====
// Shared types, constants and helpers for the transformed box bounds unit.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tbb_pkg;

  localparam int VALUE_W = 32;
  localparam int PROD_W = 2 * VALUE_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int CORNERS = 8;

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SHAPE  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_CYLINDER = 2'd0,
    KIND_ARROW    = 2'd1,
    KIND_SPHERE   = 2'd2,
    KIND_BOX      = 2'd3
  } shape_kind_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SHAPE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_kind_t;

  // A load keeps its column values in hi; a shape keeps its local box in lo/hi.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  column;
    val_t [2:0]  lo;
    val_t [2:0]  hi;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Negation that saturates the most negative value.
  function automatic val_t neg_sat(val_t v);
    val_t r;
    if (v == VAL_MIN) begin
      r = VAL_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tbb_if.sv =====
// Valid/ready channel interfaces: shape items in, bounding boxes out.
// Depends on tbb_pkg for the value type.
`timescale 1ns / 1ps
`default_nettype none

interface tbb_item_if import tbb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] column;
  val_t       val_x;
  val_t       val_y;
  val_t       val_z;
  logic [1:0] shape_kind;

  modport source (output valid, op, column, val_x, val_y, val_z, shape_kind, input ready);
  modport sink (input valid, op, column, val_x, val_y, val_z, shape_kind, output ready);
endinterface

interface tbb_box_if import tbb_pkg::*; ();
  logic valid;
  logic ready;
  val_t min_x;
  val_t min_y;
  val_t min_z;
  val_t max_x;
  val_t max_y;
  val_t max_z;
  logic is_empty;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, is_empty,
                  input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, is_empty,
                output ready);
endinterface

`default_nettype wire

// ===== sv/tbb_front.sv =====
// Front end: accepts input items, turns them into commands and queues them.
// Depends on tbb_pkg and tbb_item_if.
`timescale 1ns / 1ps
`default_nettype none

module tbb_front import tbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tbb_item_if.sink   shape_in,
  output q_head_t    head,
  input  logic       pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(QUEUE_DEPTH);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  cmd_t             cmd_next;
  logic             cmd_ok;
  logic             push;
  val_t             nx;
  val_t             ny;
  val_t             nz;

  always_comb begin
    nx = neg_sat(shape_in.val_x);
    ny = neg_sat(shape_in.val_y);
    nz = neg_sat(shape_in.val_z);
    cmd_next = '0;
    cmd_ok = 1'b0;
    case (op_t'(shape_in.op))
      OP_LOAD: begin
        cmd_ok = 1'b1;
        cmd_next.kind = CMD_LOAD;
        cmd_next.column = shape_in.column;
        cmd_next.hi = {shape_in.val_z, shape_in.val_y, shape_in.val_x};
      end
      OP_SHAPE: begin
        cmd_ok = 1'b1;
        cmd_next.kind = CMD_SHAPE;
        case (shape_kind_t'(shape_in.shape_kind))
          KIND_CYLINDER, KIND_ARROW: begin
            cmd_next.lo = {val_t'(0), nx, nx};
            cmd_next.hi = {shape_in.val_y, shape_in.val_x, shape_in.val_x};
          end
          KIND_SPHERE: begin
            cmd_next.lo = {nx, nx, nx};
            cmd_next.hi = {shape_in.val_x, shape_in.val_x, shape_in.val_x};
          end
          KIND_BOX: begin
            cmd_next.lo = {nz, ny, nx};
            cmd_next.hi = {shape_in.val_z, shape_in.val_y, shape_in.val_x};
          end
          default: cmd_next.lo = '0;
        endcase
      end
      OP_FINISH: begin
        cmd_ok = 1'b1;
        cmd_next.kind = CMD_FINISH;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  // The unused op code is taken and dropped without a queue entry.
  assign shape_in.ready = (count != FULL);
  assign push = shape_in.valid && shape_in.ready && cmd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_next;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd = mem[rd_ptr];

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid) else $error("queue popped while empty");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr) else $error("empty queue with unequal pointers");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== sv/tbb_back.sv =====
// Back end: steps through shape corners, transforms them through a multiplier
// pipeline and keeps the running box. Depends on tbb_pkg and tbb_box_if.
`timescale 1ns / 1ps
`default_nettype none

module tbb_back import tbb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      pop,
  tbb_box_if.source box_out
);

  localparam int SUM_W = PROD_W - FRAC_BITS + 2;
  typedef logic signed [SUM_W-1:0] sum_t;
  localparam prod_t HALF = prod_t'(1) << (FRAC_BITS - 1);
  localparam sum_t SAT_HI = sum_t'(VAL_MAX);
  localparam sum_t SAT_LO = sum_t'(VAL_MIN);
  localparam logic [2:0] LAST_CORNER = 3'(CORNERS - 1);

  val_t       pose [4][3];
  logic [2:0] corner;
  val_t       pt [3];
  prod_t      mul [3][3];
  logic       hold;
  logic       issue_corner;
  logic       issue_fin;
  logic       load_wr;

  logic       s1_valid;
  logic       s1_fin;
  prod_t      s1_prod [3][3];
  val_t       s1_trans [3];
  sum_t       rnd [3][3];
  sum_t       sum_next [3];

  logic       s2_valid;
  logic       s2_fin;
  sum_t       s2_sum [3];
  val_t       world [3];

  val_t       low [3];
  val_t       high [3];
  logic       seen;

  logic       out_valid;
  val_t       out_min [3];
  val_t       out_max [3];
  logic       out_empty;

  // A finish waiting on a full output register freezes the whole back end.
  assign hold = s2_valid && s2_fin && out_valid && !box_out.ready;
  assign issue_corner = head.valid && !hold && (head.cmd.kind == CMD_SHAPE);
  assign issue_fin = head.valid && !hold && (head.cmd.kind == CMD_FINISH);
  assign load_wr = head.valid && !hold && (head.cmd.kind == CMD_LOAD);
  assign pop = head.valid && !hold &&
               ((head.cmd.kind != CMD_SHAPE) || (corner == LAST_CORNER));

  always_comb begin
    pt[0] = corner[2] ? head.cmd.hi[0] : head.cmd.lo[0];
    pt[1] = corner[1] ? head.cmd.hi[1] : head.cmd.lo[1];
    pt[2] = corner[0] ? head.cmd.hi[2] : head.cmd.lo[2];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mul[r][c] = prod_t'(pose[c][r]) * prod_t'(pt[c]);
      end
    end
  end

  // Round each product to nearest, ties upward, then add the translation.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rnd[r][c] = sum_t'((s1_prod[r][c] + HALF) >>> FRAC_BITS);
      end
      sum_next[r] = sum_t'(s1_trans[r]) + rnd[r][0] + rnd[r][1] + rnd[r][2];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (s2_sum[r] > SAT_HI) begin
        world[r] = VAL_MAX;
      end else if (s2_sum[r] < SAT_LO) begin
        world[r] = VAL_MIN;
      end else begin
        world[r] = val_t'(s2_sum[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          pose[c][r] <= '0;
        end
      end
    end else if (load_wr) begin
      for (int r = 0; r < 3; r++) begin
        pose[head.cmd.column][r] <= head.cmd.hi[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
      s1_valid <= 1'b0;
      s1_fin <= 1'b0;
      s2_valid <= 1'b0;
      s2_fin <= 1'b0;
    end else if (!hold) begin
      if (issue_corner) begin
        corner <= corner + 1'b1;
      end
      s1_valid <= issue_corner || issue_fin;
      s1_fin <= issue_fin;
      s2_valid <= s1_valid;
      s2_fin <= s1_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_prod <= mul;
      s1_trans <= pose[3];
      s2_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        low[r] <= '0;
        high[r] <= '0;
      end
    end else if (s2_valid && !hold) begin
      if (s2_fin) begin
        seen <= 1'b0;
        for (int r = 0; r < 3; r++) begin
          low[r] <= '0;
          high[r] <= '0;
        end
      end else begin
        seen <= 1'b1;
        for (int r = 0; r < 3; r++) begin
          if (!seen || world[r] < low[r]) begin
            low[r] <= world[r];
          end
          if (!seen || world[r] > high[r]) begin
            high[r] <= world[r];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && s2_fin && !hold) begin
      out_valid <= 1'b1;
    end else if (box_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_fin && !hold) begin
      for (int r = 0; r < 3; r++) begin
        out_min[r] <= seen ? low[r] : '0;
        out_max[r] <= seen ? high[r] : '0;
      end
      out_empty <= !seen;
    end
  end

  assign box_out.valid = out_valid;
  assign box_out.min_x = out_min[0];
  assign box_out.min_y = out_min[1];
  assign box_out.min_z = out_min[2];
  assign box_out.max_x = out_max[0];
  assign box_out.max_y = out_max[1];
  assign box_out.max_z = out_max[2];
  assign box_out.is_empty = out_empty;

  a_corner_in_shape: assert property (@(posedge clk) disable iff (rst)
    corner != '0 |-> head.valid && head.cmd.kind == CMD_SHAPE)
    else $error("corner count running without a shape at the queue head");

  a_hold_on_finish: assert property (@(posedge clk) disable iff (rst)
    hold |=> s2_valid && s2_fin) else $error("stalled finish left the pipeline");

  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_fin && !hold |=> out_valid && !seen)
    else $error("finish did not produce a box and clear the accumulator");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_min[0] == '0 && out_max[2] == '0)
    else $error("empty box carries nonzero bounds");

endmodule

`default_nettype wire

// ===== sv/transformed_box_bounds_unit.sv =====
// Path: a finish's box passes the command queue, stages s1 and s2 and the output register
// once earlier work drains. A shape steps through eight corners, one corner per cycle through
// nine multipliers unless a held finish stalls it. A 4-entry command queue decouples the input.
// Reset (synchronous): clears the transform, the running box, the queue and the output.
// Depends on tbb_pkg, tbb_if, tbb_front and tbb_back.
`timescale 1ns / 1ps
`default_nettype none

module transformed_box_bounds_unit import tbb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  tbb_item_if.sink   shape_in,
  tbb_box_if.source  box_out
);

  q_head_t head;
  logic    pop;

  tbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .shape_in (shape_in),
    .head     (head),
    .pop      (pop)
  );

  tbb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .box_out (box_out)
  );

endmodule

`default_nettype wire

// ===== test/tbb_bounds_checker.sv =====
// Checker for the transformed box bounds unit: watches both channels, keeps its own
// transform and running box, and compares every box transfer with the predicted one.
// Depends on tbb_pkg and the channel interfaces in tbb_if.
`timescale 1ns / 1ps

module tbb_bounds_checker import tbb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  tbb_item_if  items,
  tbb_box_if   boxes,
  output int   error_count,
  output int   pending_boxes
);

  typedef struct packed {
    val_t min_x;
    val_t min_y;
    val_t min_z;
    val_t max_x;
    val_t max_y;
    val_t max_z;
    logic is_empty;
  } box_t;

  // Entry col*3+row of the pose holds row 'row' of column 'col'; column 3 is the offset.
  val_t pose [12];
  val_t span_lo [3];
  val_t span_hi [3];
  logic any_shape;
  box_t expected_boxes [$];

  function automatic val_t clamp_value(longint x);
    if (x > longint'(VAL_MAX)) begin
      return VAL_MAX;
    end
    if (x < longint'(VAL_MIN)) begin
      return VAL_MIN;
    end
    return val_t'(x);
  endfunction

  // Fixed-point product rounded to nearest, ties toward plus infinity.
  function automatic longint round_product(val_t a, val_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  task automatic absorb_shape(logic [1:0] kind, val_t x, val_t y, val_t z);
    val_t   lo [3];
    val_t   hi [3];
    val_t   pt [3];
    val_t   w;
    val_t   nx;
    longint acc;
    nx = clamp_value(-longint'(x));
    case (shape_kind_t'(kind))
      KIND_CYLINDER, KIND_ARROW: begin
        lo = '{nx, nx, val_t'(0)};
        hi = '{x, x, y};
      end
      KIND_SPHERE: begin
        lo = '{nx, nx, nx};
        hi = '{x, x, x};
      end
      default: begin
        lo = '{nx, clamp_value(-longint'(y)), clamp_value(-longint'(z))};
        hi = '{x, y, z};
      end
    endcase
    for (int c = 0; c < 8; c++) begin
      pt[0] = ((c & 4) != 0) ? hi[0] : lo[0];
      pt[1] = ((c & 2) != 0) ? hi[1] : lo[1];
      pt[2] = ((c & 1) != 0) ? hi[2] : lo[2];
      for (int row = 0; row < 3; row++) begin
        acc = longint'(pose[9 + row]);
        for (int col = 0; col < 3; col++) begin
          acc += round_product(pose[col * 3 + row], pt[col]);
        end
        w = clamp_value(acc);
        if (!any_shape || w < span_lo[row]) begin
          span_lo[row] = w;
        end
        if (!any_shape || w > span_hi[row]) begin
          span_hi[row] = w;
        end
      end
      any_shape = 1'b1;
    end
  endtask

  function automatic int check_field(string name, val_t want, val_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    box_t want;
    int   base;
    if (rst) begin
      foreach (pose[i]) pose[i] = '0;
      foreach (span_lo[i]) begin
        span_lo[i] = '0;
        span_hi[i] = '0;
      end
      any_shape = 1'b0;
      expected_boxes.delete();
      error_count = 0;
      pending_boxes = 0;
    end else begin
      if (boxes.valid && boxes.ready) begin
        if (expected_boxes.size() == 0) begin
          $error("box transfer with no finish outstanding");
          error_count++;
        end else begin
          want = expected_boxes.pop_front();
          error_count += check_field("min_x", want.min_x, boxes.min_x);
          error_count += check_field("min_y", want.min_y, boxes.min_y);
          error_count += check_field("min_z", want.min_z, boxes.min_z);
          error_count += check_field("max_x", want.max_x, boxes.max_x);
          error_count += check_field("max_y", want.max_y, boxes.max_y);
          error_count += check_field("max_z", want.max_z, boxes.max_z);
          error_count += check_field("is_empty", val_t'(want.is_empty),
                                     val_t'(boxes.is_empty));
        end
      end
      if (items.valid && items.ready) begin
        case (items.op)
          OP_LOAD: begin
            base = items.column * 3;
            pose[base]     = items.val_x;
            pose[base + 1] = items.val_y;
            pose[base + 2] = items.val_z;
          end
          OP_SHAPE: begin
            absorb_shape(items.shape_kind, items.val_x, items.val_y, items.val_z);
          end
          OP_FINISH: begin
            want.min_x = any_shape ? span_lo[0] : '0;
            want.min_y = any_shape ? span_lo[1] : '0;
            want.min_z = any_shape ? span_lo[2] : '0;
            want.max_x = any_shape ? span_hi[0] : '0;
            want.max_y = any_shape ? span_hi[1] : '0;
            want.max_z = any_shape ? span_hi[2] : '0;
            want.is_empty = !any_shape;
            expected_boxes.push_back(want);
            foreach (span_lo[i]) begin
              span_lo[i] = '0;
              span_hi[i] = '0;
            end
            any_shape = 1'b0;
          end
          default: begin
            // The spare op code leaves everything untouched.
          end
        endcase
      end
      pending_boxes = expected_boxes.size();
    end
  end

endmodule

// ===== test/tb_transformed_box_bounds_unit.sv =====
// Top of the bench for the transformed box bounds unit: clock, reset, item stimulus,
// random output stalls and the verdict. Depends on tbb_pkg, tbb_if and tbb_bounds_checker.
`timescale 1ns / 1ps

module tb_transformed_box_bounds_unit;
  import tbb_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 48;
  localparam int ITEM_TARGET = 1750;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam val_t ONE = 32'sh0001_0000;
  localparam val_t HALF = 32'sh0000_8000;

  logic clk = 1'b0;
  logic rst;
  int   error_count;
  int   pending_boxes;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   out_gap;
  bit   steady = 1'b0;

  tbb_item_if shape_in ();
  tbb_box_if  box_out ();

  transformed_box_bounds_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .shape_in(shape_in),
    .box_out (box_out)
  );

  tbb_bounds_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .items        (shape_in),
    .boxes        (box_out),
    .error_count  (error_count),
    .pending_boxes(pending_boxes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all during steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return val_t'(0);
          3: return val_t'(-1);
          4: return val_t'(1);
          5: return HALF;
          default: return -HALF;
        endcase
      end
      1, 2: return val_t'($urandom());
      default: return val_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  // Rotation entries mostly stay within plus or minus one.
  function automatic val_t pick_rotation();
    if ($urandom_range(0, 9) == 0) begin
      return pick_value();
    end
    return val_t'($urandom_range(0, 2 * 65536)) - ONE;
  endfunction

  task automatic send_item(logic [1:0] op, logic [1:0] column, val_t x, val_t y, val_t z,
                           logic [1:0] kind);
    int gap;
    shape_in.op <= op;
    shape_in.column <= column;
    shape_in.val_x <= x;
    shape_in.val_y <= y;
    shape_in.val_z <= z;
    shape_in.shape_kind <= kind;
    shape_in.valid <= 1'b1;
    do @(posedge clk); while (!shape_in.ready);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      shape_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_column(logic [1:0] column);
    if (column == 2'd3) begin
      send_item(OP_LOAD, column, pick_value(), pick_value(), pick_value(),
                2'($urandom_range(0, 3)));
    end else begin
      send_item(OP_LOAD, column, pick_rotation(), pick_rotation(), pick_rotation(),
                2'($urandom_range(0, 3)));
    end
  endtask

  task automatic send_random(logic [1:0] op);
    send_item(op, 2'($urandom_range(0, 3)), pick_value(), pick_value(), pick_value(),
              2'($urandom_range(0, 3)));
  endtask

  initial begin : output_stalls
    box_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      box_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_gap = pick_gap();
      if (out_gap > 0) begin
        box_out.ready <= 1'b0;
        repeat (out_gap) @(posedge clk);
      end
    end
  end

  // Ends the run if nothing transfers on either channel for too long.
  always @(posedge clk) begin
    if (rst || (shape_in.valid && shape_in.ready) || (box_out.valid && box_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int r;
    int n;
    rst <= 1'b1;
    shape_in.valid <= 1'b0;
    shape_in.op <= OP_LOAD;
    shape_in.column <= 2'd0;
    shape_in.val_x <= '0;
    shape_in.val_y <= '0;
    shape_in.val_z <= '0;
    shape_in.shape_kind <= KIND_CYLINDER;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty box, spare op code, shape under the all-zero pose.
    send_item(OP_FINISH, 2'd0, '0, '0, '0, KIND_CYLINDER);
    send_item(OP_UNUSED, 2'd3, VAL_MAX, VAL_MIN, val_t'(-1), KIND_BOX);
    send_item(OP_SHAPE, 2'd0, 3 * HALF, 2 * ONE, '0, KIND_CYLINDER);
    send_item(OP_FINISH, 2'd1, '0, '0, '0, KIND_SPHERE);
    // Identity rotation with a half-step offset; the kind field on loads is ignored.
    send_item(OP_LOAD, 2'd0, ONE, '0, '0, KIND_BOX);
    send_item(OP_LOAD, 2'd1, '0, ONE, '0, KIND_SPHERE);
    send_item(OP_LOAD, 2'd2, '0, '0, ONE, KIND_ARROW);
    send_item(OP_LOAD, 2'd3, HALF, -HALF, 5 * ONE, KIND_CYLINDER);
    send_item(OP_SHAPE, 2'd0, 3 * HALF, -2 * ONE, '0, KIND_CYLINDER);
    send_item(OP_SHAPE, 2'd0, -(HALF >>> 1), 3 * ONE, '0, KIND_ARROW);
    send_item(OP_SHAPE, 2'd0, VAL_MIN, '0, '0, KIND_SPHERE);
    send_item(OP_SHAPE, 2'd0, VAL_MIN, VAL_MAX, val_t'(-1), KIND_BOX);
    send_item(OP_FINISH, 2'd0, '0, '0, '0, KIND_CYLINDER);
    // Extreme pose entries drive the sums into saturation.
    send_item(OP_LOAD, 2'd0, VAL_MAX, VAL_MIN, HALF, KIND_CYLINDER);
    send_item(OP_LOAD, 2'd3, VAL_MAX, VAL_MIN, '0, KIND_CYLINDER);
    send_item(OP_SHAPE, 2'd0, VAL_MAX, VAL_MAX, VAL_MAX, KIND_BOX);
    send_item(OP_FINISH, 2'd0, '0, '0, '0, KIND_CYLINDER);
    // Half-unit entries times one LSB land exactly on a rounding tie.
    send_item(OP_LOAD, 2'd1, HALF, -HALF, VAL_MIN, KIND_CYLINDER);
    send_item(OP_SHAPE, 2'd0, val_t'(1), val_t'(1), val_t'(1), KIND_BOX);
    send_item(OP_SHAPE, 2'd0, VAL_MAX, '0, '0, KIND_SPHERE);
    send_item(OP_FINISH, 2'd0, '0, '0, '0, KIND_CYLINDER);
    send_item(OP_FINISH, 2'd0, '0, '0, '0, KIND_CYLINDER);

    // Random part: occasional pose updates, a run of shapes and usually a finish.
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        for (int col = 0; col < 4; col++) begin
          load_column(2'(col));
        end
      end else if (r < 25) begin
        load_column(2'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 19) == 0) begin
        send_random(OP_UNUSED);
      end
      n = $urandom_range(0, 5);
      repeat (n) send_random(OP_SHAPE);
      // Sometimes the finish is left out so shapes pile into the next box.
      if ($urandom_range(0, 14) != 0) begin
        send_random(OP_FINISH);
      end
    end

    steady = 1'b0;
    shape_in.valid <= 1'b0;
    // Let the checker record the last transfer before its queue is polled.
    @(posedge clk);
    while (pending_boxes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
